>>> rtl/tsm_pkg.sv
// shared types and constants of the square tone mixer
package tsm_pkg;

  localparam int CFG_IDX_W     = 3;
  localparam int NUM_HALF_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_BASE       = 3'd2;

  localparam logic [1:0] MODE_NORMAL     = 2'd0;
  localparam logic [1:0] MODE_FULL       = 2'd1;
  localparam logic [1:0] MODE_NORMAL_SIL = 2'd2;
  localparam logic [1:0] MODE_FULL_SIL   = 2'd3;

  localparam logic [1:0] TICK_MODE_RESET = MODE_FULL;
  localparam logic [2:0] ACTIVE_RESET    = 3'd4;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_wr_t;

  typedef struct packed {
    logic        en;
    logic [31:0] ref_time;
  } svc_t;

endpackage

>>> rtl/multichannel_square_tone_mixer.sv
// Square tone mixer: one request per tick carrying the microsecond time; each tick
// produces the pin writes of the selected mode (full sweep or round-robin, with or
// without low writes for silent channels), the final write of a tick marked by tlast.
// One shared deadline compare and add unit services one channel per cycle unless the
// output stalls; sweep modes visit the n channels in use, then make the final write;
// plain round-robin hunts for the next active channel, round-robin with silence
// writes the next channel. Input ready is held low until the tick is done.
module multichannel_square_tone_mixer import tsm_pkg::*; #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // now_us
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // pin_level, zero fill
  output logic                 m_tlast
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [1:0]      tick_mode;
  logic [2:0]      active_channels;
  cfg_wr_t         cfg;
  svc_t            svc;
  logic [CH_W-1:0] sel;
  logic            sel_active;
  logic            sel_level;

  assign cfg_ready = !rst;
  assign cfg.en    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_mode       <= TICK_MODE_RESET;
      active_channels <= ACTIVE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TICK_MODE) begin
        tick_mode <= cfg_data[1:0];
      end
      if (cfg_index == REG_ACTIVE_CHANNELS) begin
        active_channels <= cfg_data[2:0];
      end
    end
  end

  tsm_chan #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_chan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sel       (sel),
    .svc       (svc),
    .sel_active(sel_active),
    .sel_level (sel_level)
  );

  tsm_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .tick_mode      (tick_mode),
    .active_channels(active_channels),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .sel            (sel),
    .svc            (svc),
    .sel_active     (sel_active),
    .sel_level      (sel_level)
  );

endmodule

>>> rtl/tsm_chan.sv
// per-channel tone state with the shared deadline compare and add unit
module tsm_chan import tsm_pkg::*; #(
  parameter int NUM_CHANNELS = 4,
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  cfg_wr_t         cfg,
  input  logic [CH_W-1:0] sel,
  input  svc_t            svc,
  output logic            sel_active,
  output logic            sel_level
);

  logic [31:0]             half_period [NUM_CHANNELS];
  logic [31:0]             deadline [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] levels;

  logic [31:0] sel_half;
  logic [31:0] sel_deadline;
  logic        fire;
  logic [31:0] new_deadline;

  for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_half
    if (k < NUM_HALF_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          half_period[k] <= '0;
        end else if (cfg.en && cfg.index == REG_HALF_BASE + CFG_IDX_W'(k)) begin
          half_period[k] <= cfg.data;
        end
      end
    end else begin : g_none
      assign half_period[k] = '0;
    end
  end

  // shared unit: one channel serviced per cycle while svc.en is set
  assign sel_half     = half_period[sel];
  assign sel_deadline = deadline[sel];
  assign fire         = sel_deadline <= svc.ref_time;
  assign new_deadline = svc.ref_time + sel_half;
  assign sel_active   = sel_half != '0;
  assign sel_level    = levels[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        deadline[i] <= '0;
      end
    end else if (svc.en && fire) begin
      levels[sel]   <= ~levels[sel];
      deadline[sel] <= new_deadline;
    end
  end

endmodule

>>> rtl/tsm_ctrl.sv
// tick sequencer: sweep and round-robin walk over channels, output register
module tsm_ctrl import tsm_pkg::*; #(
  parameter int NUM_CHANNELS = 4,
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      tick_mode,
  input  logic [2:0]      active_channels,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [31:0]     s_tdata,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast,
  output logic [CH_W-1:0] sel,
  output svc_t            svc,
  input  logic            sel_active,
  input  logic            sel_level
);

  localparam int CNT_W = CH_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_HUNT  = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [31:0]      now_t, now_t_next;
  logic [31:0]      latched, latched_next;
  logic [CH_W-1:0]  ptr, ptr_next;
  logic [CH_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0] tries, tries_next;
  logic             out_valid;
  logic             out_level;
  logic             out_last;

  logic [CNT_W-1:0] n;
  logic             full;
  logic             silent_low;
  logic             can_emit;
  logic [CNT_W-1:0] adv_inc;
  logic             wrap;
  logic [CH_W-1:0]  adv_ptr;
  logic             emit;
  logic             emit_level;
  logic             emit_last;

  always_comb begin
    if (active_channels == 3'd0) begin
      n = CNT_W'(1);
    end else if ({1'b0, active_channels} > 4'(NUM_CHANNELS)) begin
      n = CNT_W'(NUM_CHANNELS);
    end else begin
      n = CNT_W'(active_channels);
    end
  end

  assign full       = (tick_mode == MODE_FULL) || (tick_mode == MODE_FULL_SIL);
  assign silent_low = (tick_mode == MODE_NORMAL_SIL) || (tick_mode == MODE_FULL_SIL);
  assign can_emit   = !out_valid || m_tready;
  assign adv_inc    = {1'b0, ptr} + CNT_W'(1);
  assign wrap       = adv_inc >= n;
  assign adv_ptr    = wrap ? '0 : adv_inc[CH_W-1:0];
  assign sel        = (state == ST_HUNT) ? adv_ptr : idx;
  assign s_tready   = (state == ST_IDLE) && !rst;

  always_comb begin
    state_next   = state;
    now_t_next   = now_t;
    latched_next = latched;
    ptr_next     = ptr;
    idx_next     = idx;
    tries_next   = tries;
    emit         = 1'b0;
    emit_level   = 1'b0;
    emit_last    = 1'b0;
    svc.en       = 1'b0;
    svc.ref_time = latched;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          now_t_next = s_tdata;
          if (full) begin
            latched_next = s_tdata;
            idx_next     = '0;
            state_next   = ST_SWEEP;
          end else begin
            tries_next = '0;
            state_next = ST_HUNT;
          end
        end
      end
      ST_SWEEP: begin
        if (can_emit || !(sel_active || silent_low)) begin
          if (sel_active || silent_low) begin
            emit       = 1'b1;
            emit_level = sel_active & sel_level;
            svc.en     = sel_active;
          end
          if ({1'b0, idx} == n - CNT_W'(1)) begin
            state_next = ST_FINAL;
          end else begin
            idx_next = idx + CH_W'(1);
          end
        end
      end
      ST_FINAL: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          ptr_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_HUNT: begin
        svc.ref_time = wrap ? now_t : latched;
        if (can_emit) begin
          ptr_next = adv_ptr;
          if (wrap) begin
            latched_next = now_t;
          end
          if (sel_active || silent_low) begin
            emit       = 1'b1;
            emit_level = sel_active & sel_level;
            emit_last  = 1'b1;
            svc.en     = sel_active;
            state_next = ST_IDLE;
          end else begin
            tries_next = tries + CNT_W'(1);
            if (tries == n) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      latched <= '0;
      ptr     <= '0;
      idx     <= '0;
      tries   <= '0;
    end else begin
      state   <= state_next;
      latched <= latched_next;
      ptr     <= ptr_next;
      idx     <= idx_next;
      tries   <= tries_next;
    end
  end

  always_ff @(posedge clk) begin
    now_t <= now_t_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_level <= emit_level;
      out_last  <= emit_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_level};
  assign m_tlast  = out_last;

endmodule
